### sv/ash_pkg.sv
// Shared types and constants for the ARX sponge hash.
// No dependencies; imported by every module of the block.
package ash_pkg;

    localparam int ROUNDS        = 8;    // mixing rounds per permutation
    localparam int MAX_OUT_WORDS = 256;  // squeeze length ceiling
    localparam int RATE          = 8;    // rate words per block
    localparam int WORD_W        = 64;
    localparam int LEN_W         = 16;   // message length field
    localparam int CNT_W         = 4;    // 0..RATE word count
    localparam int OWORD_W       = 9;    // out_words register
    localparam int STEPS         = 4 * ROUNDS;  // half-G steps per permutation
    localparam int STEP_W        = $clog2(STEPS);

    localparam int S_TDATA_W = 528;  // 8 words + length, byte aligned
    localparam int M_TDATA_W = 520;  // 8 words + valid count, byte aligned

    localparam logic [WORD_W-1:0] PAD_LOW = 64'h0000_0000_0000_0001;
    localparam logic [WORD_W-1:0] PAD_TOP = 64'h8000_0000_0000_0000;

    // configuration register indexes
    localparam logic REG_DOMAIN    = 1'b0;
    localparam logic REG_OUT_WORDS = 1'b1;

    typedef logic [WORD_W-1:0]           word_t;
    typedef logic [RATE-1:0][WORD_W-1:0] blk_t;
    typedef logic [15:0][WORD_W-1:0]     sstate_t;

    // controller -> datapath
    typedef struct packed {
        logic             absorb;     // xor block into rate words
        logic             init;       // start from cleared state first
        logic [CNT_W-1:0] data_cnt;   // input words taken, 0..RATE
        logic             pad;        // apply 10*1 padding at data_cnt
        logic             step;       // one half-G step on all four lanes
        logic [1:0]       phase;      // [1]: diagonal, [0]: second half
        logic             emit;       // load output register
        logic [CNT_W-1:0] emit_cnt;
        logic             emit_final;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register can take a new block this cycle
    } sts_t;

endpackage

### sv/ash_dp.sv
// Datapath: 16-word sponge state, absorb/padding logic, four half-G lanes
// and the output register. Depends on ash_pkg; sequenced by ash_ctrl.
module ash_dp import ash_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  blk_t                 in_words,
    input  logic [LEN_W-1:0]     msg_words,
    input  word_t                domain,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_word_0..out_word_7, valid_words, zero fill
    output logic                 m_tlast    // final_output
);

    sstate_t          v_reg, v_next;
    blk_t             ow_reg, ow_next;
    logic [CNT_W-1:0] vw_reg, vw_next;
    logic             last_reg, last_next;
    logic             valid_reg, valid_next;

    sstate_t base;
    sstate_t v_step;
    blk_t    blk;
    word_t   a, b, c, d, a2, b2, c2, d2;
    logic [3:0] ia, ib, ic, id;

    function automatic word_t ror64(word_t x, int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    assign sts.out_free = !valid_reg || m_tready;

    always_comb begin
        // block to absorb: data words below data_cnt, then padding
        for (int i = 0; i < RATE; i++) begin
            blk[i] = (CNT_W'(i) < cmd.data_cnt) ? in_words[i] : '0;
            if (cmd.pad && CNT_W'(i) == cmd.data_cnt) blk[i] = blk[i] ^ PAD_LOW;
            if (cmd.pad && i == RATE - 1)             blk[i] = blk[i] ^ PAD_TOP;
        end

        base = v_reg;
        if (cmd.init) begin
            base     = '0;
            base[15] = domain ^ {{(WORD_W-LEN_W-8){1'b0}}, msg_words, 8'h00};
        end

        // four G lanes, column or diagonal selection
        v_step = v_reg;
        for (int j = 0; j < 4; j++) begin
            ia = 4'(j);
            ib = 4'(4  + ((j + (cmd.phase[1] ? 1 : 0)) & 3));
            ic = 4'(8  + ((j + (cmd.phase[1] ? 2 : 0)) & 3));
            id = 4'(12 + ((j + (cmd.phase[1] ? 3 : 0)) & 3));
            a  = v_reg[ia];
            b  = v_reg[ib];
            c  = v_reg[ic];
            d  = v_reg[id];
            a2 = a + b;
            d2 = cmd.phase[0] ? ror64(d ^ a2, 16) : ror64(d ^ a2, 32);
            c2 = c + d2;
            b2 = cmd.phase[0] ? ror64(b ^ c2, 63) : ror64(b ^ c2, 24);
            v_step[ia] = a2;
            v_step[ib] = b2;
            v_step[ic] = c2;
            v_step[id] = d2;
        end

        v_next = v_reg;
        if (cmd.absorb) begin
            v_next = base;
            for (int i = 0; i < RATE; i++) v_next[i] = base[i] ^ blk[i];
        end else if (cmd.step) begin
            v_next = v_step;
        end

        ow_next    = ow_reg;
        vw_next    = vw_reg;
        last_next  = last_reg;
        valid_next = valid_reg && !m_tready;
        if (cmd.emit) begin
            for (int i = 0; i < RATE; i++)
                ow_next[i] = (CNT_W'(i) < cmd.emit_cnt) ? v_reg[i] : '0;
            vw_next    = cmd.emit_cnt;
            last_next  = cmd.emit_final;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg    <= v_next;
        ow_reg   <= ow_next;
        vw_reg   <= vw_next;
        last_reg <= last_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(M_TDATA_W-RATE*WORD_W-CNT_W){1'b0}}, vw_reg, ow_reg};

    a_vw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (vw_reg != '0 && vw_reg <= CNT_W'(RATE)))
        else $error("output word count out of range");

    a_unused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && vw_reg < CNT_W'(RATE)) |-> ow_reg[RATE-1] == '0)
        else $error("word beyond valid count not cleared");

    a_emit_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> valid_reg)
        else $error("emitted block not presented");

endmodule

### sv/ash_ctrl.sv
// Controller FSM: absorb sequencing, permutation step counter, padding-only
// block and squeeze loop. Depends on ash_pkg; drives ash_dp by command.
module ash_ctrl import ash_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               last_block,
    input  logic [LEN_W-1:0]   msg_words,
    input  logic [OWORD_W-1:0] out_words,
    input  sts_t               sts,
    output cmd_t               cmd
);

    typedef enum logic [1:0] {IDLE, PERM, POST, EMIT} state_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               first_reg, first_next;
    logic               padq_reg, padq_next;     // padding-only block owed
    logic               squeeze_reg, squeeze_next;
    logic [OWORD_W-1:0] remain_reg, remain_next;

    logic               accept;
    logic [OWORD_W-1:0] want;
    logic               full_last;

    assign s_tready  = (state_reg == IDLE);
    assign accept    = s_tvalid && s_tready;
    assign full_last = (msg_words != '0) && (msg_words[2:0] == 3'd0);

    always_comb begin
        if (out_words == '0)                              want = OWORD_W'(1);
        else if (out_words > OWORD_W'(MAX_OUT_WORDS))     want = OWORD_W'(MAX_OUT_WORDS);
        else                                              want = out_words;
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        first_next   = first_reg;
        padq_next    = padq_reg;
        squeeze_next = squeeze_reg;
        remain_next  = remain_reg;
        cmd          = '0;
        cmd.phase    = step_reg[1:0];

        unique case (state_reg)
            IDLE: begin
                if (accept) begin
                    cmd.absorb = 1'b1;
                    cmd.init   = first_reg;
                    first_next = 1'b0;
                    if (!last_block || full_last) begin
                        cmd.data_cnt = CNT_W'(RATE);
                    end else begin
                        cmd.data_cnt = {1'b0, msg_words[2:0]};
                        cmd.pad      = 1'b1;
                    end
                    padq_next    = last_block && full_last;
                    squeeze_next = last_block;
                    if (last_block) remain_next = want;
                    step_next  = '0;
                    state_next = PERM;
                end
            end
            PERM: begin
                cmd.step  = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1)) state_next = POST;
            end
            POST: begin
                step_next = '0;
                if (padq_reg) begin
                    cmd.absorb = 1'b1;
                    cmd.pad    = 1'b1;
                    padq_next  = 1'b0;
                    state_next = PERM;
                end else if (squeeze_reg) begin
                    state_next = EMIT;
                end else begin
                    state_next = IDLE;
                end
            end
            EMIT: begin
                if (sts.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_cnt   = (remain_reg >= OWORD_W'(RATE)) ? CNT_W'(RATE)
                                                                     : remain_reg[CNT_W-1:0];
                    cmd.emit_final = (remain_reg <= OWORD_W'(RATE));
                    if (remain_reg <= OWORD_W'(RATE)) begin
                        remain_next  = '0;
                        squeeze_next = 1'b0;
                        first_next   = 1'b1;
                        state_next   = IDLE;
                    end else begin
                        remain_next = remain_reg - OWORD_W'(RATE);
                        step_next   = '0;
                        state_next  = PERM;
                    end
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            step_reg    <= '0;
            first_reg   <= 1'b1;
            padq_reg    <= 1'b0;
            squeeze_reg <= 1'b0;
            remain_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            first_reg   <= first_next;
            padq_reg    <= padq_next;
            squeeze_reg <= squeeze_next;
            remain_reg  <= remain_next;
        end
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free)
        else $error("output register overwritten");

    a_remain_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EMIT) |-> (remain_reg != '0 && squeeze_reg))
        else $error("squeeze with nothing left");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step || cmd.emit) |-> !s_tready)
        else $error("input taken while state busy");

    a_perm_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == PERM && step_reg == STEP_W'(STEPS - 1)) |=> state_reg == POST)
        else $error("permutation length wrong");

endmodule

### sv/arx_sponge_hash.sv
// Sponge hash over a 16-word state with BLAKE2b-style G mixing.
// A permutation runs half a G step per cycle on four lanes, then the POST decision
// state; s_tready is high only in IDLE, so no new block is taken until both are done.
// A last block adds one more permutation if its data fills the rate, then
// squeezes up to 8 words per permutation, each block held in an output register.
// Reset (aresetn, synchronous, active low) clears control, domain=0, out_words=4.
module arx_sponge_hash import ash_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [WORD_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // word_0..word_7, message_words
    input  logic                 s_tlast,   // last_block
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_word_0..out_word_7, valid_words, zero fill
    output logic                 m_tlast    // final_output
);

    word_t              domain_reg;
    logic [OWORD_W-1:0] out_words_reg;
    cmd_t               cmd;
    sts_t               sts;
    blk_t               in_words;
    logic [LEN_W-1:0]   msg_words;

    assign in_words  = s_tdata[RATE*WORD_W-1:0];
    assign msg_words = s_tdata[RATE*WORD_W +: LEN_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            domain_reg    <= '0;
            out_words_reg <= OWORD_W'(4);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DOMAIN:    domain_reg    <= cfg_wdata;
                REG_OUT_WORDS: out_words_reg <= cfg_wdata[OWORD_W-1:0];
                default: ;
            endcase
        end
    end

    ash_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .last_block (s_tlast),
        .msg_words  (msg_words),
        .out_words  (out_words_reg),
        .sts        (sts),
        .cmd        (cmd)
    );

    ash_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_words  (in_words),
        .msg_words (msg_words),
        .domain    (domain_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
